// ===== rtl/ccpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpt_pkg
// Shared types and constants of the cluster chain page translator.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpt_pkg;

	localparam int TABLE_ENTRIES     = 32768;
	localparam int HANDLE_COUNT      = 16;
	localparam int PAGES_PER_CLUSTER = 8;
	localparam int PAGE_BYTES        = 2048;

	localparam int TBL_AW    = $clog2(TABLE_ENTRIES);
	localparam int HANDLE_W  = 4;
	localparam int OFF_W     = $clog2(PAGE_BYTES);
	localparam int CNT_W     = OFF_W + 1;
	localparam int PNUM_W    = $clog2(PAGES_PER_CLUSTER);
	localparam int CLU_OFF_W = OFF_W + PNUM_W;
	localparam int WANT_W    = 32 - CLU_OFF_W;
	localparam int CMP_W     = 18;

	localparam logic [15:0] END_MARK       = 16'hffff;
	localparam logic [15:0] FDC_RESET      = 16'd64;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_OPEN  = 2'd1,
		REQ_CLOSE = 2'd2,
		REQ_XLATE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EOF    = 2'd1,
		ST_CHAIN  = 2'd2,
		ST_CLOSED = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t              req_type;
		logic [14:0]            table_index;
		logic [15:0]            table_value;
		logic [HANDLE_W-1:0]    handle;
		logic [15:0]            start_cluster;
		logic [31:0]            file_length;
		logic [31:0]            byte_position;
		logic [31:0]            request_length;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [15:0]            cluster_found;
		logic [31:0]            flash_page;
		logic [10:0]            page_offset;
		logic [11:0]            bytes_in_page;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_stop;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cluster_chain_page_translator.sv =====
// ----------------------------------------------------------------------------
// cluster_chain_page_translator
// Maps a file byte position to a flash page by walking a cluster chain table.
// ----------------------------------------------------------------------------
// One word is handled at a time. Table writes, opens, closes and translates
// that end early (closed handle, past end of file) give their result in the
// cycle after acceptance. A translate that walks follows chain links from the
// handle's cached point (or from the first cluster when the position moved
// backward or the cached point is a chain end); the walk reads one table
// entry per cycle from the single-read chain table memory. The chain table
// needs no clearing after reset; an entry must be written before any walk
// reaches it. first_data_cluster may be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cluster_chain_page_translator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ccpt_pkg::req_t req_word,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output ccpt_pkg::rsp_t      rsp_word,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_wdata
);
	import ccpt_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ccpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ccpt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== rtl/ccpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccpt_ctrl
// Request sequencer: accepts words, runs the chain walk, owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	input  wire ccpt_pkg::ctl_sts_t sts,
	output ccpt_pkg::ctl_cmd_t      cmd
);
	import ccpt_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready  = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid  = rsp_valid_q;
	assign cmd.accept = req_valid && req_ready;
	assign cmd.step   = (state_q == S_WALK) && !sts.walk_stop;
	assign cmd.finish = (state_q == S_WALK) && sts.walk_stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						if (sts.need_walk) begin
							state_q     <= S_WALK;
							rsp_valid_q <= 1'b0;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end else if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_WALK: begin
					if (sts.walk_stop) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ccpt_datapath.sv =====
// ----------------------------------------------------------------------------
// ccpt_datapath
// Chain table, handle file, position split, walk registers and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpt_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ccpt_pkg::req_t     req_word,
	output ccpt_pkg::rsp_t          rsp_word,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	input  wire ccpt_pkg::ctl_cmd_t cmd,
	output ccpt_pkg::ctl_sts_t      sts
);
	import ccpt_pkg::*;

	logic [15:0]          table_mem [TABLE_ENTRIES];
	logic [15:0]          rd_q;
	logic [TBL_AW-1:0]    rd_addr;

	logic                 valid_q  [HANDLE_COUNT];
	logic [15:0]          start_q  [HANDLE_COUNT];
	logic [31:0]          len_q    [HANDLE_COUNT];
	logic [WANT_W-1:0]    cidx_q   [HANDLE_COUNT];
	logic [15:0]          cclu_q   [HANDLE_COUNT];
	logic [15:0]          fdc_q;

	logic [HANDLE_W-1:0]  h_q;
	logic [WANT_W-1:0]    want_q;
	logic [PNUM_W-1:0]    pnum_q;
	logic [OFF_W-1:0]     poff_q;
	logic [CNT_W-1:0]     cnt1_q;
	logic [31:0]          left_q;
	logic [15:0]          clu_q, clu_d;
	logic [WANT_W-1:0]    idx_q, idx_d;
	rsp_t                 rsp_q;

	logic [HANDLE_W-1:0]  h;
	logic                 in_range, live, eof, cache_ok, is_xlate, tbl_ok;
	logic [WANT_W-1:0]    want;
	logic [OFF_W-1:0]     poff;
	logic [CNT_W-1:0]     room, cnt1;
	logic                 ended;
	logic [31:0]          diff;
	logic [CNT_W-1:0]     cnt_fin;
	rsp_t                 early;
	rsp_t                 done_word;

	assign h        = req_word.handle;
	assign in_range = CMP_W'(req_word.handle) < CMP_W'(HANDLE_COUNT);
	assign live     = in_range && valid_q[h];
	assign eof      = req_word.byte_position >= len_q[h];
	assign is_xlate = req_word.req_type == REQ_XLATE;
	assign tbl_ok   = CMP_W'(req_word.table_index) < CMP_W'(TABLE_ENTRIES);
	assign want     = req_word.byte_position[31:CLU_OFF_W];
	assign poff     = req_word.byte_position[OFF_W-1:0];
	assign room     = CNT_W'(PAGE_BYTES) - CNT_W'(poff);
	assign cnt1     = (req_word.request_length < 32'(room)) ?
	                  req_word.request_length[CNT_W-1:0] : room;
	assign cache_ok = (CMP_W'(cclu_q[h]) < CMP_W'(TABLE_ENTRIES)) && (want >= cidx_q[h]);

	assign sts.need_walk = is_xlate && live && !eof;
	assign ended         = CMP_W'(clu_q) >= CMP_W'(TABLE_ENTRIES);
	assign sts.walk_stop = ended || (idx_q == want_q);

	assign diff    = 32'(clu_q) - 32'(fdc_q);
	assign cnt_fin = (left_q < 32'(cnt1_q)) ? left_q[CNT_W-1:0] : cnt1_q;

	// walk registers and next read address
	always_comb begin
		clu_d = clu_q;
		idx_d = idx_q;
		if (cmd.accept && is_xlate) begin
			clu_d = cache_ok ? cclu_q[h] : start_q[h];
			idx_d = cache_ok ? cidx_q[h] : '0;
		end else if (cmd.step) begin
			clu_d = rd_q;
			idx_d = idx_q + 1'b1;
		end
	end
	assign rd_addr = clu_d[TBL_AW-1:0];

	// result for words that need no walk
	always_comb begin
		early = '0;
		case (req_word.req_type)
			REQ_WRITE: early.status = ST_OK;
			REQ_OPEN:  early.status = in_range ? ST_OK : ST_CLOSED;
			REQ_CLOSE: early.status = live ? ST_OK : ST_CLOSED;
			REQ_XLATE: early.status = !live ? ST_CLOSED : ST_EOF;
			default:   early.status = ST_CLOSED;
		endcase
	end

	always_comb begin
		done_word = '0;
		if (ended) begin
			done_word.status        = ST_CHAIN;
			done_word.cluster_found = END_MARK;
		end else begin
			done_word.status        = ST_OK;
			done_word.cluster_found = clu_q;
			done_word.flash_page    = {diff[31-PNUM_W:0], pnum_q};
			done_word.page_offset   = 11'(poff_q);
			done_word.bytes_in_page = 12'(cnt_fin);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (req_word.req_type == REQ_WRITE) && tbl_ok) begin
			table_mem[req_word.table_index[TBL_AW-1:0]] <= req_word.table_value;
		end
		rd_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HANDLE_COUNT; i++) begin
				valid_q[i] <= 1'b0;
			end
			fdc_q <= FDC_RESET;
		end else begin
			if (cfg_we) begin
				fdc_q <= cfg_wdata;
			end
			if (cmd.accept && in_range) begin
				if (req_word.req_type == REQ_OPEN) begin
					valid_q[h] <= 1'b1;
				end else if ((req_word.req_type == REQ_CLOSE) && live) begin
					valid_q[h] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		clu_q <= clu_d;
		idx_q <= idx_d;
		if (cmd.accept) begin
			h_q    <= h;
			want_q <= want;
			pnum_q <= req_word.byte_position[CLU_OFF_W-1:OFF_W];
			poff_q <= poff;
			cnt1_q <= cnt1;
			left_q <= len_q[h] - req_word.byte_position;
			if (!sts.need_walk) begin
				rsp_q <= early;
			end
			if ((req_word.req_type == REQ_OPEN) && in_range) begin
				start_q[h] <= req_word.start_cluster;
				len_q[h]   <= req_word.file_length;
				cidx_q[h]  <= '0;
				cclu_q[h]  <= req_word.start_cluster;
			end
		end
		if (cmd.finish) begin
			cidx_q[h_q] <= want_q;
			cclu_q[h_q] <= ended ? END_MARK : clu_q;
			rsp_q       <= done_word;
		end
	end

	assign rsp_word = rsp_q;

endmodule

`default_nettype wire
